/* hdl/mcc_pkg.sv */
// ----------------------------------------------------------------------------
// Morse codec package
// Shared character codes, field widths, table entry type and pattern mask.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 4;
    localparam int IDX_W  = 6;
    localparam int GAP_W  = 4;
    localparam int TAIL_W = 3;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [GAP_W-1:0]  GAP_LOOKUP = 4'd3;
    localparam logic [GAP_W-1:0]  GAP_SPACE  = 4'd7;
    localparam logic [GAP_W-1:0]  GAP_MAX    = 4'd15;

    localparam logic [TAIL_W-1:0] WORD_SPACES = 3'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } t_entry;

    function automatic logic [CHAR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CHAR_W-1:0] m;
        if (len >= 4'd8) begin
            m = 8'hFF;
        end else begin
            m = (8'd1 << len[2:0]) - 8'd1;
        end
        return m;
    endfunction

endpackage

/* hdl/morse_code_codec_unit.sv */
// ----------------------------------------------------------------------------
// Morse code codec unit
// Loadable character/pattern table in a synchronous memory; encodes text
// characters to dot/dash beats and decodes a dot/dash/gap stream to text.
// Load, symbol and plain gap items are taken with no result.
// Encode or decode lookup: a table scan (one memory read per cycle),
// then the result beats in order, held while the output stalls.
// One item at a time: new input stalls until the last result beat is issued.
// Reset clears control and pending pattern state; table contents stay
// undefined until loaded, with no clearing pass.
// ----------------------------------------------------------------------------
module morse_code_codec_unit #(
    parameter int TABLE_ENTRIES = 36,
    parameter int MAX_SYMBOLS   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_mode,
    input  logic [mcc_pkg::CHAR_W-1:0] i_char_in,
    input  logic [mcc_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [mcc_pkg::CHAR_W-1:0] i_entry_symbol,
    input  logic [mcc_pkg::CHAR_W-1:0] i_entry_pattern,
    input  logic [mcc_pkg::LEN_W-1:0]  i_entry_length,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mcc_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_last
);
    import mcc_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EMIT} t_state;

    t_state              r_state, n_state;
    logic                r_op_dec, n_op_dec;
    logic [CHAR_W-1:0]   r_key, n_key;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_cmp_vld, n_cmp_vld;
    logic [CHAR_W-1:0]   r_pbits, n_pbits;
    logic [LEN_W-1:0]    r_plen, n_plen;
    logic                r_povf, n_povf;
    logic [GAP_W-1:0]    r_gap, n_gap;
    logic                r_head_vld, n_head_vld;
    logic [CHAR_W-1:0]   r_head_char, n_head_char;
    logic [CHAR_W-1:0]   r_sym_bits, n_sym_bits;
    logic [LEN_W-1:0]    r_sym_idx, n_sym_idx;
    logic [LEN_W-1:0]    r_sym_len, n_sym_len;
    logic [TAIL_W-1:0]   r_tail_cnt, n_tail_cnt;
    logic [CHAR_W-1:0]   r_tail_char, n_tail_char;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_last, n_last;

    t_entry              mem [TABLE_ENTRIES];
    t_entry              r_rd;
    t_entry              wr_entry;
    logic                wr_en;
    logic [LEN_W-1:0]    wr_len;

    logic                accept;
    logic                out_free;
    logic                issue;
    logic                hit;
    logic                sym_left;
    logic                more;
    logic [GAP_W-1:0]    gap_inc;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign wr_len   = (i_entry_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS)
                                                            : i_entry_length;
    assign wr_entry = '{ch: i_entry_symbol, bits: i_entry_pattern, len: wr_len};
    assign wr_en    = accept && (i_mode == MODE_LOAD) &&
                      ({1'b0, i_entry_index} < 7'(TABLE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_entry_index[AW-1:0]] <= wr_entry;
        end
        r_rd <= mem[r_addr[AW-1:0]];
    end

    assign issue    = (r_state == S_SEARCH) && (r_addr < CW'(TABLE_ENTRIES));
    assign hit      = r_op_dec ? ((r_rd.len == r_plen) &&
                                  (((r_rd.bits ^ r_pbits) & len_mask(r_rd.len)) == '0))
                               : (r_rd.ch == r_key);
    assign sym_left = (r_sym_idx != r_sym_len);
    assign gap_inc  = (r_gap == GAP_MAX) ? r_gap : r_gap + 4'd1;

    always_comb begin
        n_state     = r_state;
        n_op_dec    = r_op_dec;
        n_key       = r_key;
        n_addr      = r_addr;
        n_cmp_vld   = 1'b0;
        n_pbits     = r_pbits;
        n_plen      = r_plen;
        n_povf      = r_povf;
        n_gap       = r_gap;
        n_head_vld  = r_head_vld;
        n_head_char = r_head_char;
        n_sym_bits  = r_sym_bits;
        n_sym_idx   = r_sym_idx;
        n_sym_len   = r_sym_len;
        n_tail_cnt  = r_tail_cnt;
        n_tail_char = r_tail_char;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_out_char  = r_out_char;
        n_last      = r_last;
        more        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_head_vld  = 1'b0;
                    n_sym_idx   = '0;
                    n_sym_len   = '0;
                    n_tail_cnt  = '0;
                    n_tail_char = CH_SPACE;
                    n_addr      = '0;
                    n_key       = i_char_in;
                    case (i_mode)
                        MODE_ENCODE: begin
                            n_op_dec = 1'b0;
                            if (i_char_in == CH_NEWLINE) begin
                                n_tail_cnt  = 3'd1;
                                n_tail_char = CH_NEWLINE;
                                n_state     = S_EMIT;
                            end else if (i_char_in == CH_SPACE) begin
                                n_tail_cnt = WORD_SPACES;
                                n_state    = S_EMIT;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        MODE_DECODE: begin
                            n_op_dec = 1'b1;
                            if (i_char_in == CH_DOT || i_char_in == CH_DASH) begin
                                if (r_plen < LEN_W'(MAX_SYMBOLS)) begin
                                    if (i_char_in == CH_DASH) begin
                                        n_pbits = r_pbits | (8'd1 << r_plen[2:0]);
                                    end
                                    n_plen = r_plen + 4'd1;
                                end else begin
                                    n_povf = 1'b1;
                                end
                                n_gap = '0;
                            end else if (i_char_in == CH_NEWLINE ||
                                         gap_inc == GAP_LOOKUP) begin
                                if (i_char_in == CH_NEWLINE) begin
                                    n_tail_cnt  = 3'd1;
                                    n_tail_char = CH_NEWLINE;
                                end else begin
                                    n_gap = gap_inc;
                                end
                                if (r_povf) begin
                                    n_head_vld  = 1'b1;
                                    n_head_char = CH_SPACE;
                                    n_pbits     = '0;
                                    n_plen      = '0;
                                    n_povf      = 1'b0;
                                    n_state     = S_EMIT;
                                end else begin
                                    n_state = S_SEARCH;
                                end
                            end else begin
                                n_gap = gap_inc;
                                if (gap_inc == GAP_SPACE) begin
                                    n_tail_cnt = 3'd1;
                                    n_state    = S_EMIT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (issue) begin
                    n_addr    = r_addr + CW'(1);
                    n_cmp_vld = 1'b1;
                end
                if ((r_cmp_vld && hit) || (!r_cmp_vld && !issue)) begin
                    n_cmp_vld = 1'b0;
                    if (r_op_dec) begin
                        n_head_vld  = 1'b1;
                        n_head_char = r_cmp_vld ? r_rd.ch : CH_SPACE;
                        n_pbits     = '0;
                        n_plen      = '0;
                        n_povf      = 1'b0;
                        n_state     = S_EMIT;
                    end else if (r_cmp_vld) begin
                        n_sym_bits = r_rd.bits;
                        n_sym_len  = r_rd.len;
                        n_tail_cnt = 3'd1;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_head_vld) begin
                        n_out_char = r_head_char;
                        n_head_vld = 1'b0;
                        more       = sym_left || (r_tail_cnt != '0);
                    end else if (sym_left) begin
                        n_out_char = r_sym_bits[r_sym_idx[2:0]] ? CH_DASH : CH_DOT;
                        n_sym_idx  = r_sym_idx + 4'd1;
                        more       = (n_sym_idx != r_sym_len) || (r_tail_cnt != '0);
                    end else begin
                        n_out_char = r_tail_char;
                        n_tail_cnt = r_tail_cnt - 3'd1;
                        more       = (r_tail_cnt != 3'd1);
                    end
                    n_last = !more;
                    if (!more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_pbits     <= '0;
            r_plen      <= '0;
            r_povf      <= 1'b0;
            r_gap       <= '0;
            r_head_vld  <= 1'b0;
            r_sym_idx   <= '0;
            r_sym_len   <= '0;
            r_tail_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_pbits     <= n_pbits;
            r_plen      <= n_plen;
            r_povf      <= n_povf;
            r_gap       <= n_gap;
            r_head_vld  <= n_head_vld;
            r_sym_idx   <= n_sym_idx;
            r_sym_len   <= n_sym_len;
            r_tail_cnt  <= n_tail_cnt;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
        end
        r_op_dec    <= n_op_dec;
        r_key       <= n_key;
        r_head_char <= n_head_char;
        r_sym_bits  <= n_sym_bits;
        r_tail_char <= n_tail_char;
        r_out_char  <= n_out_char;
        r_last      <= n_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;

    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= LEN_W'(MAX_SYMBOLS))
        else $error("pending pattern longer than allowed");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_head_vld || sym_left || (r_tail_cnt != '0)))
        else $error("emit state with nothing left to send");

    a_sym_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym_idx <= r_sym_len)
        else $error("symbol index past pattern length");

    a_symbol_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_DECODE) &&
         (i_char_in == CH_DOT || i_char_in == CH_DASH)) |=> (r_state == S_IDLE))
        else $error("symbol beat left the idle state");

endmodule

/* test/morse_code_codec_checker.sv */
// ----------------------------------------------------------------------------
// Morse codec checker
// Watches both channels of the codec, runs its own copy of the table and the
// pending pattern on every accepted input beat, queues the characters that
// beat should produce, and compares each accepted output beat against the
// oldest queued character and its last flag.
// ----------------------------------------------------------------------------
module morse_code_codec_checker #(
    parameter int TABLE_ENTRIES = 36,
    parameter int MAX_SYMBOLS   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [1:0]                 i_mode,
    input  logic [mcc_pkg::CHAR_W-1:0] i_char_in,
    input  logic [mcc_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [mcc_pkg::CHAR_W-1:0] i_entry_symbol,
    input  logic [mcc_pkg::CHAR_W-1:0] i_entry_pattern,
    input  logic [mcc_pkg::LEN_W-1:0]  i_entry_length,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [mcc_pkg::CHAR_W-1:0] i_out_char,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_due_count,
    output int                         o_beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcc_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    logic [CHAR_W-1:0] tbl_ch   [TABLE_ENTRIES];
    logic [CHAR_W-1:0] tbl_bits [TABLE_ENTRIES];
    logic [LEN_W-1:0]  tbl_len  [TABLE_ENTRIES];
    logic [CHAR_W-1:0] pat_bits;
    logic [LEN_W-1:0]  pat_len;
    logic              pat_ovf;
    logic [GAP_W-1:0]  gap_run;
    t_char_beat        due_chars [$];

    // look up the pending pattern, first matching slot wins, then clear it
    function automatic logic [CHAR_W-1:0] take_pattern();
        logic [CHAR_W-1:0] hit;
        logic [CHAR_W-1:0] m;
        logic              found;
        hit   = CH_SPACE;
        found = 1'b0;
        if (!pat_ovf) begin
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
                m = (tbl_len[s] >= 4'd8) ? 8'hFF : ((8'd1 << tbl_len[s]) - 8'd1);
                if (!found && tbl_len[s] == pat_len && (tbl_bits[s] & m) == (pat_bits & m)) begin
                    hit   = tbl_ch[s];
                    found = 1'b1;
                end
            end
        end
        pat_bits = '0;
        pat_len  = '0;
        pat_ovf  = 1'b0;
        return hit;
    endfunction

    task automatic translate_item(
        input logic [1:0]        mode,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx,
        input logic [CHAR_W-1:0] sym,
        input logic [CHAR_W-1:0] pat,
        input logic [LEN_W-1:0]  len
    );
        logic [CHAR_W-1:0] outs [$];
        logic              found;
        t_char_beat        beat;
        found = 1'b0;
        case (mode)
            MODE_LOAD: begin
                if (idx < TABLE_ENTRIES) begin
                    tbl_ch[idx]   = sym;
                    tbl_bits[idx] = pat;
                    if (len > MAX_SYMBOLS) tbl_len[idx] = LEN_W'(MAX_SYMBOLS);
                    else tbl_len[idx] = len;
                end
            end
            MODE_ENCODE: begin
                if (ch == CH_NEWLINE) begin
                    outs.push_back(CH_NEWLINE);
                end else if (ch == CH_SPACE) begin
                    repeat (WORD_SPACES) outs.push_back(CH_SPACE);
                end else begin
                    for (int s = 0; s < TABLE_ENTRIES; s++) begin
                        if (!found && tbl_ch[s] == ch) begin
                            found = 1'b1;
                            for (int k = 0; k < tbl_len[s]; k++)
                                outs.push_back(tbl_bits[s][k] ? CH_DASH : CH_DOT);
                            outs.push_back(CH_SPACE);
                        end
                    end
                end
            end
            MODE_DECODE: begin
                if (ch == CH_DOT || ch == CH_DASH) begin
                    if (pat_len < MAX_SYMBOLS) begin
                        if (ch == CH_DASH) pat_bits[pat_len] = 1'b1;
                        pat_len = pat_len + 1'b1;
                    end else begin
                        pat_ovf = 1'b1;
                    end
                    gap_run = '0;
                end else if (ch == CH_NEWLINE) begin
                    outs.push_back(take_pattern());
                    outs.push_back(CH_NEWLINE);
                end else begin
                    if (gap_run < GAP_MAX) gap_run = gap_run + 1'b1;
                    if (gap_run == GAP_LOOKUP) outs.push_back(take_pattern());
                    if (gap_run == GAP_SPACE) outs.push_back(CH_SPACE);
                end
            end
            default: ;
        endcase
        for (int k = 0; k < outs.size(); k++) begin
            beat.ch   = outs[k];
            beat.last = (k == outs.size() - 1);
            due_chars.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            pat_bits        = '0;
            pat_len         = '0;
            pat_ovf         = 1'b0;
            gap_run         = '0;
            o_fail_count    = 0;
            o_beats_checked = 0;
            due_chars.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_chars.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got out_char=%h last=%b",
                             $time, i_out_char, i_last);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = due_chars.pop_front();
                    if (i_out_char !== want.ch || i_last !== want.last) begin
                        if (i_out_char !== want.ch)
                            $display("%0t: out_char expected %h got %h",
                                     $time, want.ch, i_out_char);
                        if (i_last !== want.last)
                            $display("%0t: last expected %b got %b",
                                     $time, want.last, i_last);
                        o_fail_count = o_fail_count + 1;
                    end
                    o_beats_checked = o_beats_checked + 1;
                end
            end
            if (i_in_valid && !i_in_stall)
                translate_item(i_mode, i_char_in, i_entry_index, i_entry_symbol,
                               i_entry_pattern, i_entry_length);
        end
        o_due_count = due_chars.size();
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Morse codec testbench
// Loads the whole pattern table, runs a short directed sequence through the
// encode, decode, load and unused paths, then a long random mix of well-formed
// Morse words, overflowing patterns, gap runs, reloads and noise, with bursty
// input, a patterned output stall, one long output hold-off and full drains.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcc_pkg::*;

    localparam int         TABLE_ENTRIES  = 36;
    localparam int         MAX_SYMBOLS    = 8;
    localparam int         ITEM_TARGET    = 400;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_mode;
    logic [CHAR_W-1:0] i_char_in;
    logic [IDX_W-1:0]  i_entry_index;
    logic [CHAR_W-1:0] i_entry_symbol;
    logic [CHAR_W-1:0] i_entry_pattern;
    logic [LEN_W-1:0]  i_entry_length;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_last;

    int fail_count;
    int due_count;
    int beats_checked;

    logic [CHAR_W-1:0] sh_sym  [TABLE_ENTRIES];
    logic [CHAR_W-1:0] sh_bits [TABLE_ENTRIES];
    logic [LEN_W-1:0]  sh_len  [TABLE_ENTRIES];

    int burst_left;
    bit keep_offering;
    int hold_off_asks;
    int hold_off_seen;
    int idle_cycles = 0;
    int n_items, n_load, n_encode, n_decode, n_ignored;

    morse_code_codec_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_SYMBOLS   (MAX_SYMBOLS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_entry_index   (i_entry_index),
        .i_entry_symbol  (i_entry_symbol),
        .i_entry_pattern (i_entry_pattern),
        .i_entry_length  (i_entry_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_last          (o_last)
    );

    morse_code_codec_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_SYMBOLS   (MAX_SYMBOLS)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_entry_index   (i_entry_index),
        .i_entry_symbol  (i_entry_symbol),
        .i_entry_pattern (i_entry_pattern),
        .i_entry_length  (i_entry_length),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_char      (o_out_char),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_due_count     (due_count),
        .o_beats_checked (beats_checked)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: stall style is redrawn when its random span runs out, long hold-off on request
    initial begin
        int style;
        int span;
        i_out_stall   = 1'b0;
        hold_off_seen = 0;
        style         = 0;
        span          = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_seen != hold_off_asks) begin
                hold_off_seen = hold_off_asks;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 80);
            end
            span = span - 1;
            case (style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                2: i_out_stall <= span[0];
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_beat(
        input logic [1:0]        mode,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx,
        input logic [CHAR_W-1:0] sym,
        input logic [CHAR_W-1:0] pat,
        input logic [LEN_W-1:0]  len
    );
        @(negedge i_clk);
        if (burst_left == 0 && !keep_offering) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
        end
        i_mode          <= mode;
        i_char_in       <= ch;
        i_entry_index   <= idx;
        i_entry_symbol  <= sym;
        i_entry_pattern <= pat;
        i_entry_length  <= len;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!keep_offering) burst_left = burst_left - 1;
        if (mode == MODE_UNUSED || (mode == MODE_LOAD && idx >= TABLE_ENTRIES)) begin
            n_ignored = n_ignored + 1;
        end else begin
            n_items = n_items + 1;
            if (mode == MODE_LOAD) n_load = n_load + 1;
            else if (mode == MODE_ENCODE) n_encode = n_encode + 1;
            else n_decode = n_decode + 1;
        end
    endtask

    task automatic send_text(input logic [1:0] mode, input logic [CHAR_W-1:0] ch);
        send_beat(mode, ch, IDX_W'($urandom_range(0, 63)), CHAR_W'($urandom),
                  CHAR_W'($urandom), LEN_W'($urandom_range(0, 15)));
    endtask

    task automatic load_entry(
        input logic [IDX_W-1:0]  idx,
        input logic [CHAR_W-1:0] sym,
        input logic [CHAR_W-1:0] pat,
        input logic [LEN_W-1:0]  len
    );
        if (idx < TABLE_ENTRIES) begin
            sh_sym[idx]  = sym;
            sh_bits[idx] = pat;
            sh_len[idx]  = (len > MAX_SYMBOLS) ? LEN_W'(MAX_SYMBOLS) : len;
        end
        send_beat(MODE_LOAD, CHAR_W'($urandom), idx, sym, pat, len);
    endtask

    function automatic logic [CHAR_W-1:0] pick_gap_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_DOT || c == CH_DASH || c == CH_NEWLINE);
        return c;
    endfunction

    task automatic send_gaps(input int count);
        repeat (count) send_text(MODE_DECODE, pick_gap_char());
    endtask

    // emit one slot's symbols, with a stray gap or two between symbols now and then
    task automatic stream_slot(input int slot);
        for (int k = 0; k < sh_len[slot]; k++) begin
            if (k > 0 && $urandom_range(0, 5) == 0) send_gaps($urandom_range(1, 2));
            send_text(MODE_DECODE, sh_bits[slot][k] ? CH_DASH : CH_DOT);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait (due_count == 0);
    endtask

    initial begin
        int  slot;
        int  roll;
        int  next_drain;
        bit  held;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_LOAD;
        i_char_in       = '0;
        i_entry_index   = '0;
        i_entry_symbol  = '0;
        i_entry_pattern = '0;
        i_entry_length  = '0;
        burst_left      = 0;
        keep_offering   = 1'b0;
        hold_off_asks   = 0;
        n_items   = 0;
        n_load    = 0;
        n_encode  = 0;
        n_decode  = 0;
        n_ignored = 0;
        held       = 1'b0;
        next_drain = 50;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot before any search can run
        for (slot = 0; slot < TABLE_ENTRIES; slot++)
            load_entry(IDX_W'(slot),
                       CHAR_W'((slot < 26) ? 8'h41 + slot : 8'h30 + slot - 26),
                       CHAR_W'($urandom), LEN_W'($urandom_range(1, MAX_SYMBOLS)));

        load_entry(6'h3F, 8'hFF, 8'hFF, 4'hF);
        send_text(MODE_UNUSED, CHAR_W'($urandom));
        send_text(MODE_ENCODE, CH_SPACE);
        send_text(MODE_ENCODE, CH_NEWLINE);
        send_text(MODE_ENCODE, 8'hFF);
        send_text(MODE_ENCODE, 8'h00);
        load_entry(6'd35, 8'hFF, 8'hFF, 4'hF);
        send_text(MODE_ENCODE, 8'hFF);
        load_entry(6'd34, 8'h00, 8'h00, 4'h0);
        send_text(MODE_ENCODE, 8'h00);
        send_text(MODE_DECODE, CH_NEWLINE);
        load_entry(6'd33, 8'h3F, 8'hFE, 4'h1);
        send_text(MODE_DECODE, CH_DOT);
        send_text(MODE_DECODE, 8'h00);
        send_gaps(GAP_LOOKUP - 1);
        send_gaps(GAP_SPACE - GAP_LOOKUP);
        drain_results();

        while (n_items < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (!held && n_items >= ITEM_TARGET / 2) begin
                held = 1'b1;
                hold_off_asks = hold_off_asks + 1;
                keep_offering = 1'b1;
                repeat (25) send_text(MODE_ENCODE, sh_sym[$urandom_range(0, TABLE_ENTRIES - 1)]);
                keep_offering = 1'b0;
            end else if (roll < 40) begin
                stream_slot($urandom_range(0, TABLE_ENTRIES - 1));
                roll = $urandom_range(0, 9);
                if (roll < 5) send_gaps(GAP_LOOKUP);
                else if (roll < 8) send_text(MODE_DECODE, CH_NEWLINE);
                else send_gaps($urandom_range(GAP_SPACE, 18));
            end else if (roll < 50) begin
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 4))
                        send_text(MODE_DECODE, $urandom_range(0, 1) ? CH_DASH : CH_DOT);
                    if ($urandom_range(0, 1) == 0) send_text(MODE_DECODE, CH_NEWLINE);
                    else send_gaps(GAP_LOOKUP);
                end else begin
                    repeat (6) begin
                        roll = $urandom_range(0, 3);
                        send_text(MODE_DECODE, (roll == 0) ? CH_DOT : (roll == 1) ? CH_DASH :
                                  (roll == 2) ? CH_NEWLINE : pick_gap_char());
                    end
                end
            end else if (roll < 82) begin
                roll = $urandom_range(0, 19);
                if (roll < 14) send_text(MODE_ENCODE, sh_sym[$urandom_range(0, TABLE_ENTRIES - 1)]);
                else if (roll < 16) send_text(MODE_ENCODE, CH_SPACE);
                else if (roll < 17) send_text(MODE_ENCODE, CH_NEWLINE);
                else send_text(MODE_ENCODE, CHAR_W'($urandom));
            end else if (roll < 92) begin
                load_entry(IDX_W'($urandom_range(0, TABLE_ENTRIES - 1)),
                           $urandom_range(0, 2) ? CHAR_W'(8'h41 + $urandom_range(0, 25))
                                                : CHAR_W'($urandom),
                           CHAR_W'($urandom),
                           $urandom_range(0, 4) ? LEN_W'($urandom_range(1, MAX_SYMBOLS))
                                                : LEN_W'($urandom_range(0, 15)));
            end else if (roll < 96) begin
                send_text(MODE_UNUSED, CHAR_W'($urandom));
            end else begin
                load_entry(IDX_W'($urandom_range(TABLE_ENTRIES, 63)), CHAR_W'($urandom),
                           CHAR_W'($urandom), LEN_W'($urandom_range(0, 15)));
            end
            if (n_items >= next_drain) begin
                drain_results();
                next_drain = n_items + $urandom_range(30, 80);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (due_count == 0);
        repeat (100) @(posedge i_clk);

        $display("input beats: %0d loads, %0d encodes, %0d decodes, %0d ignored",
                 n_load, n_encode, n_decode, n_ignored);
        $display("output beats compared: %0d, mismatches: %0d", beats_checked, fail_count);
        if (fail_count == 0 && due_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
